>>> sv/lqci_pkg.sv
// Shared widths, register indexes, control struct and level start table for the cell index block.
`default_nettype none

package lqci_pkg;

   localparam int DEF_MAX_LEVELS = 8;
   localparam int DEF_COORD_BITS = 16;

   localparam int LEVEL_W   = 4;
   localparam int CELL_W    = 8;
   localparam int INDEX_W   = 17;
   localparam int SIZE_W    = 15;
   localparam int DEN_W     = SIZE_W + 1;
   localparam int REM_W     = DEN_W + 1;
   localparam int CSR_W     = SIZE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCENE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCENE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL    = 2'd2;

   localparam logic [SIZE_W-1:0]  RST_SCENE_SIZE = 15'd1024;
   localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL  = 4'd8;

   typedef struct packed {
      logic [LEVEL_W-1:0] lvl;
      logic               neg_x;
      logic               over_x;
      logic               neg_y;
      logic               over_y;
   } cell_ctl_type;

   // first node of a level: sum of 4^k for k below the level, kept to the index width
   function automatic logic [INDEX_W-1:0] level_start(input logic [LEVEL_W-1:0] lvl);
      logic [INDEX_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < (1 << LEVEL_W) - 1; k++) begin
         if (LEVEL_W'(k) < lvl) begin
            acc = acc | (INDEX_W'(1) << (2 * k));
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

>>> sv/lqci_axis_level.sv
// Tree level allowed by one axis extent against the scene size.
`default_nettype none

module lqci_axis_level
   import lqci_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic signed [COORD_BITS:0] ext,
   input  wire logic [SIZE_W-1:0]          size,
   input  wire logic [LEVEL_W-1:0]         cap,
   output logic [LEVEL_W-1:0]              lvl
);

   localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

   logic [SIZE_W-1:0]     size_m1;
   logic [COORD_BITS-1:0] ext_mag;
   logic                  ext_empty;
   logic [LEVEL_W-1:0]    cnt;
   logic [SIZE_W-1:0]     thr;

   assign size_m1   = size - SIZE_W'(1);
   assign ext_mag   = ext[COORD_BITS-1:0];
   assign ext_empty = ext[COORD_BITS] || (ext == '0);

   // ext << d < size holds exactly when ext <= (size - 1) >> d
   always_comb begin
      cnt = '0;
      thr = '0;
      for (int d = 1; d <= MAX_LEVELS; d++) begin
         thr = size_m1 >> d;
         if ((LEVEL_W'(d) <= cap) && (CMP_W'(ext_mag) <= CMP_W'(thr))) begin
            cnt = cnt + LEVEL_W'(1);
         end
      end
   end

   assign lvl = ext_empty ? cap : cnt;

endmodule

`default_nettype wire

>>> sv/lqci_div_step.sv
// One registered restoring division step producing one fraction bit of center over scene size.
`default_nettype none

module lqci_div_step
   import lqci_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [REM_W-1:0]      rem_in,
   input  wire logic [MAX_LEVELS-1:0] frac_in,
   input  wire logic [DEN_W-1:0]      den,
   output logic [REM_W-1:0]           rem_out,
   output logic [MAX_LEVELS-1:0]      frac_out
);

   logic [REM_W-1:0]      rem_ff;
   logic [REM_W-1:0]      rem_in_d;
   logic [MAX_LEVELS-1:0] frac_ff;
   logic [MAX_LEVELS-1:0] frac_in_d;
   logic [REM_W-1:0]      rem_dbl;
   logic                  fits;

   assign rem_dbl   = {rem_in[REM_W-2:0], 1'b0};
   assign fits      = rem_dbl >= REM_W'(den);
   assign rem_in_d  = fits ? (rem_dbl - REM_W'(den)) : rem_dbl;
   assign frac_in_d = MAX_LEVELS'({frac_in, fits});

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in_d;
         frac_ff <= frac_in_d;
      end
   end

   assign rem_out  = rem_ff;
   assign frac_out = frac_ff;

endmodule

`default_nettype wire

>>> sv/lqci_index.sv
// Cell clamp and linear node index from the finished fractions and the chosen level.
`default_nettype none

module lqci_index
   import lqci_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input  wire cell_ctl_type          ctl,
   input  wire logic [MAX_LEVELS-1:0] frac_x,
   input  wire logic [MAX_LEVELS-1:0] frac_y,
   output logic [MAX_LEVELS-1:0]      cell_x,
   output logic [MAX_LEVELS-1:0]      cell_y,
   output logic [INDEX_W-1:0]         index
);

   logic [LEVEL_W-1:0]    drop;
   logic [MAX_LEVELS-1:0] max_cell;
   logic [MAX_LEVELS-1:0] q_x;
   logic [MAX_LEVELS-1:0] q_y;

   assign drop     = LEVEL_W'(MAX_LEVELS) - ctl.lvl;
   assign max_cell = ~({MAX_LEVELS{1'b1}} << ctl.lvl);
   assign q_x      = frac_x >> drop;
   assign q_y      = frac_y >> drop;

   assign cell_x = ctl.neg_x ? '0 : (ctl.over_x ? max_cell : q_x);
   assign cell_y = ctl.neg_y ? '0 : (ctl.over_y ? max_cell : q_y);

   assign index = level_start(ctl.lvl) + (INDEX_W'(cell_y) << ctl.lvl) + INDEX_W'(cell_x);

endmodule

`default_nettype wire

>>> sv/loose_quadtree_cell_index.sv
// Loose quadtree cell index: one box per beat in, its level, cell and node index out.
// The block takes one box per clock while req_stall is low and returns one result beat
// per box, in order. The pipeline has an input register, a level and setup stage, one
// stage per level for the bit-serial division of the box center by the scene size, and
// an output register. Each stage holds its beat only while the stage after it is full
// and stalled, so bubbles close up and a stalled result does not block input until
// every stage is full. Scene sizes of zero act as one, and max_level above MAX_LEVELS
// is capped. Change configuration only when no beat is in flight.
`default_nettype none

module loose_quadtree_cell_index
   import lqci_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         csr_write,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_W-1:0]             csr_data,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_left_edge,
   input  wire logic signed [COORD_BITS-1:0] req_right_edge,
   input  wire logic signed [COORD_BITS-1:0] req_top_edge,
   input  wire logic signed [COORD_BITS-1:0] req_bottom_edge,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [CELL_W-1:0]                 rsp_cell_x,
   output logic [CELL_W-1:0]                 rsp_cell_y,
   output logic [LEVEL_W-1:0]                rsp_level,
   output logic [INDEX_W-1:0]                rsp_cell_index
);

   localparam int NSTAGE = MAX_LEVELS + 3;
   localparam int OUT_ST = NSTAGE - 1;
   localparam int CMP_W  = (COORD_BITS > DEN_W) ? COORD_BITS : DEN_W;

   // configuration
   logic [SIZE_W-1:0]  scene_width_ff;
   logic [SIZE_W-1:0]  scene_height_ff;
   logic [LEVEL_W-1:0] max_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scene_width_ff  <= RST_SCENE_SIZE;
         scene_height_ff <= RST_SCENE_SIZE;
         max_level_ff    <= RST_MAX_LEVEL;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCENE_WIDTH:  scene_width_ff  <= csr_data;
            CSR_SCENE_HEIGHT: scene_height_ff <= csr_data;
            CSR_MAX_LEVEL:    max_level_ff    <= csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0]  size_x;
   logic [SIZE_W-1:0]  size_y;
   logic [DEN_W-1:0]   den_x;
   logic [DEN_W-1:0]   den_y;
   logic [LEVEL_W-1:0] cap;

   assign size_x = (scene_width_ff == '0) ? SIZE_W'(1) : scene_width_ff;
   assign size_y = (scene_height_ff == '0) ? SIZE_W'(1) : scene_height_ff;
   assign den_x  = {size_x, 1'b0};
   assign den_y  = {size_y, 1'b0};
   assign cap    = (max_level_ff > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : max_level_ff;

   // valid bits and advance chain
   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE:0]   stage_load;

   always_comb begin
      stage_load[NSTAGE] = !rsp_stall;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         stage_load[k] = !v_ff[k] || stage_load[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_load[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (stage_load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !stage_load[0];

   // stage 0: sums and extents
   logic signed [COORD_BITS:0] sum_x_ff;
   logic signed [COORD_BITS:0] sum_y_ff;
   logic signed [COORD_BITS:0] ext_x_ff;
   logic signed [COORD_BITS:0] ext_y_ff;

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         sum_x_ff <= (COORD_BITS+1)'(req_left_edge) + (COORD_BITS+1)'(req_right_edge);
         sum_y_ff <= (COORD_BITS+1)'(req_top_edge) + (COORD_BITS+1)'(req_bottom_edge);
         ext_x_ff <= (COORD_BITS+1)'(req_right_edge) - (COORD_BITS+1)'(req_left_edge);
         ext_y_ff <= (COORD_BITS+1)'(req_bottom_edge) - (COORD_BITS+1)'(req_top_edge);
      end
   end

   // stage 1: level choice and division setup
   logic [LEVEL_W-1:0]    lvl_x;
   logic [LEVEL_W-1:0]    lvl_y;
   logic [COORD_BITS-1:0] mag_x;
   logic [COORD_BITS-1:0] mag_y;
   cell_ctl_type          ctl_in;

   lqci_axis_level #(
      .MAX_LEVELS (MAX_LEVELS),
      .COORD_BITS (COORD_BITS)
   ) u_level_x (
      .ext  (ext_x_ff),
      .size (size_x),
      .cap  (cap),
      .lvl  (lvl_x)
   );

   lqci_axis_level #(
      .MAX_LEVELS (MAX_LEVELS),
      .COORD_BITS (COORD_BITS)
   ) u_level_y (
      .ext  (ext_y_ff),
      .size (size_y),
      .cap  (cap),
      .lvl  (lvl_y)
   );

   assign mag_x = sum_x_ff[COORD_BITS-1:0];
   assign mag_y = sum_y_ff[COORD_BITS-1:0];

   always_comb begin
      ctl_in.lvl    = (lvl_x < lvl_y) ? lvl_x : lvl_y;
      ctl_in.neg_x  = sum_x_ff[COORD_BITS];
      ctl_in.neg_y  = sum_y_ff[COORD_BITS];
      ctl_in.over_x = !sum_x_ff[COORD_BITS] && (CMP_W'(mag_x) >= CMP_W'(den_x));
      ctl_in.over_y = !sum_y_ff[COORD_BITS] && (CMP_W'(mag_y) >= CMP_W'(den_y));
   end

   cell_ctl_type     ctl_ff [1:MAX_LEVELS+1];
   logic [REM_W-1:0] rem_x_init_ff;
   logic [REM_W-1:0] rem_y_init_ff;

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         ctl_ff[1]     <= ctl_in;
         rem_x_init_ff <= REM_W'(mag_x);
         rem_y_init_ff <= REM_W'(mag_y);
      end
   end

   // stages 2 .. MAX_LEVELS+1: one fraction bit per stage
   logic [REM_W-1:0]      rem_x  [0:MAX_LEVELS];
   logic [REM_W-1:0]      rem_y  [0:MAX_LEVELS];
   logic [MAX_LEVELS-1:0] frac_x [0:MAX_LEVELS];
   logic [MAX_LEVELS-1:0] frac_y [0:MAX_LEVELS];

   assign rem_x[0]  = rem_x_init_ff;
   assign rem_y[0]  = rem_y_init_ff;
   assign frac_x[0] = '0;
   assign frac_y[0] = '0;

   for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_div
      lqci_div_step #(
         .MAX_LEVELS (MAX_LEVELS)
      ) u_step_x (
         .clock    (clock),
         .load     (stage_load[j+2]),
         .rem_in   (rem_x[j]),
         .frac_in  (frac_x[j]),
         .den      (den_x),
         .rem_out  (rem_x[j+1]),
         .frac_out (frac_x[j+1])
      );

      lqci_div_step #(
         .MAX_LEVELS (MAX_LEVELS)
      ) u_step_y (
         .clock    (clock),
         .load     (stage_load[j+2]),
         .rem_in   (rem_y[j]),
         .frac_in  (frac_y[j]),
         .den      (den_y),
         .rem_out  (rem_y[j+1]),
         .frac_out (frac_y[j+1])
      );

      always_ff @(posedge clock) begin
         if (stage_load[j+2]) begin
            ctl_ff[j+2] <= ctl_ff[j+1];
         end
      end
   end

   // output stage
   logic [MAX_LEVELS-1:0] cell_x;
   logic [MAX_LEVELS-1:0] cell_y;
   logic [INDEX_W-1:0]    index;

   lqci_index #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_index (
      .ctl    (ctl_ff[MAX_LEVELS+1]),
      .frac_x (frac_x[MAX_LEVELS]),
      .frac_y (frac_y[MAX_LEVELS]),
      .cell_x (cell_x),
      .cell_y (cell_y),
      .index  (index)
   );

   logic [CELL_W-1:0]  cell_x_ff;
   logic [CELL_W-1:0]  cell_y_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [INDEX_W-1:0] cell_index_ff;

   always_ff @(posedge clock) begin
      if (stage_load[OUT_ST]) begin
         cell_x_ff     <= CELL_W'(cell_x);
         cell_y_ff     <= CELL_W'(cell_y);
         level_ff      <= ctl_ff[MAX_LEVELS+1].lvl;
         cell_index_ff <= index;
      end
   end

   assign rsp_valid      = v_ff[OUT_ST];
   assign rsp_cell_x     = cell_x_ff;
   assign rsp_cell_y     = cell_y_ff;
   assign rsp_level      = level_ff;
   assign rsp_cell_index = cell_index_ff;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff) && rsp_stall)
      else $error("input stalled while a pipeline stage is empty");

   a_level_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= cap)
      else $error("result level above the level cap");

   a_root_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_level == '0) |->
         (rsp_cell_x == '0) && (rsp_cell_y == '0) && (rsp_cell_index == '0))
      else $error("root level result with nonzero cell");

   a_output_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index))
      else $error("stalled result lost or changed");

endmodule

`default_nettype wire

>>> tb/tb_loose_quadtree_cell_index.sv
// Self-checking testbench for the loose quadtree cell index block.
`timescale 1ns / 100ps

module tb_loose_quadtree_cell_index
   import lqci_pkg::*;
();

   localparam int COORD_W    = DEF_COORD_BITS;
   localparam int PIPE_DEPTH = DEF_MAX_LEVELS + 3;
   localparam int IDLE_LIMIT = 4000;
   localparam int N_PROBES   = 15;
   localparam int N_SETTINGS = 8;
   localparam int BOXES_PER_SETTING = 190;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] left_edge;
      logic signed [COORD_W-1:0] right_edge;
      logic signed [COORD_W-1:0] top_edge;
      logic signed [COORD_W-1:0] bottom_edge;
   } box_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic [LEVEL_W-1:0] level;
      logic [INDEX_W-1:0] cell_index;
   } cell_type;

   typedef struct packed {
      box_type  box;
      logic     fixed;
      cell_type want;
   } probe_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_data  = '0;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_left_edge   = '0;
   logic signed [COORD_W-1:0] req_right_edge  = '0;
   logic signed [COORD_W-1:0] req_top_edge    = '0;
   logic signed [COORD_W-1:0] req_bottom_edge = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CELL_W-1:0]         rsp_cell_x;
   logic [CELL_W-1:0]         rsp_cell_y;
   logic [LEVEL_W-1:0]        rsp_level;
   logic [INDEX_W-1:0]        rsp_cell_index;

   loose_quadtree_cell_index u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_edge   (req_left_edge),
      .req_right_edge  (req_right_edge),
      .req_top_edge    (req_top_edge),
      .req_bottom_edge (req_bottom_edge),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_level       (rsp_level),
      .rsp_cell_index  (rsp_cell_index)
   );

   always #6 clock = ~clock;

   logic [SIZE_W-1:0]  scene_w_ff;
   logic [SIZE_W-1:0]  scene_h_ff;
   logic [LEVEL_W-1:0] max_level_ff;

   logic     beat_fixed = 1'b0;
   cell_type beat_want  = '0;

   cell_type expected_cells[$];
   int    mismatches  = 0;
   int    idle_cycles = 0;
   bit    tx_quiet    = 1'b0;
   bit    rx_quiet    = 1'b0;
   int    burst_left  = 0;
   int    stall_left  = 0;
   bit    stall_on    = 1'b0;

   int scene_w_list [N_SETTINGS] = '{32767, 1, 0, 100, 5000, 32767, 256, 1024};
   int scene_h_list [N_SETTINGS] = '{32767, 1, 0, 3000, 37, 1, 256, 1024};
   int max_lvl_list [N_SETTINGS] = '{8, 0, 15, 4, 9, 1, 8, 3};
   bit quiet_list   [N_SETTINGS] = '{0, 0, 1, 0, 0, 0, 1, 0};

   function automatic int fit_depth(input longint lo, input longint hi,
                                    input longint size, input int cap);
      longint ext;
      int     n;
      int     d;
      ext = hi - lo;
      if (ext <= 0) return cap;
      n = 0;
      for (d = 1; d <= cap && (ext << d) < size; d++) n++;
      return n;
   endfunction

   function automatic longint center_cell(input longint lo, input longint hi,
                                          input longint size, input int lvl);
      longint sum;
      longint q;
      longint top;
      sum = lo + hi;
      if (sum < 0) return 0;
      top = (longint'(1) << lvl) - 1;
      q = (sum << lvl) / (2 * size);
      return (q > top) ? top : q;
   endfunction

   function automatic cell_type cell_of_box(input box_type b);
      longint   sw;
      longint   sh;
      int       cap;
      int       lvl;
      int       ly;
      longint   cx;
      longint   cy;
      longint   start;
      cell_type c;
      sw  = (scene_w_ff == 0) ? 1 : longint'(scene_w_ff);
      sh  = (scene_h_ff == 0) ? 1 : longint'(scene_h_ff);
      cap = (max_level_ff > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : int'(max_level_ff);
      lvl = fit_depth(longint'(b.left_edge), longint'(b.right_edge), sw, cap);
      ly  = fit_depth(longint'(b.top_edge), longint'(b.bottom_edge), sh, cap);
      if (ly < lvl) lvl = ly;
      cx = center_cell(longint'(b.left_edge), longint'(b.right_edge), sw, lvl);
      cy = center_cell(longint'(b.top_edge), longint'(b.bottom_edge), sh, lvl);
      start = ((longint'(1) << (2 * lvl)) - 1) / 3;
      c.cell_x     = CELL_W'(cx);
      c.cell_y     = CELL_W'(cy);
      c.level      = LEVEL_W'(lvl);
      c.cell_index = INDEX_W'(start + (cy << lvl) + cx);
      return c;
   endfunction

   function automatic probe_type make_probe(input int l, input int r, input int t,
                                            input int b, input bit fixed, input int x,
                                            input int y, input int lv, input int idx);
      probe_type p;
      p.box  = {COORD_W'(l), COORD_W'(r), COORD_W'(t), COORD_W'(b)};
      p.fixed = fixed;
      p.want = {CELL_W'(x), CELL_W'(y), LEVEL_W'(lv), INDEX_W'(idx)};
      return p;
   endfunction

   function automatic void random_span(input int size, output logic [COORD_W-1:0] lo,
                                       output logic [COORD_W-1:0] hi);
      int s;
      int ext;
      int c;
      int a;
      s   = (size == 0) ? 1 : size;
      ext = $urandom_range(0, (s >> $urandom_range(0, 10)) + 1);
      c   = int'($urandom_range(0, 3 * s / 2)) - s / 4;
      a   = c - ext / 2;
      if ($urandom_range(0, 15) == 0) begin
         lo = COORD_W'(a + ext);
         hi = COORD_W'(a);
      end else begin
         lo = COORD_W'(a);
         hi = COORD_W'(a + ext);
      end
   endfunction

   function automatic box_type random_box();
      box_type b;
      if ($urandom_range(0, 3) == 0) begin
         b = {COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
      end else begin
         random_span(int'(scene_w_ff), b.left_edge, b.right_edge);
         random_span(int'(scene_h_ff), b.top_edge, b.bottom_edge);
      end
      return b;
   endfunction

   // present one box, hold it until taken, then maybe open a gap
   task automatic send_box(input box_type b, input logic fixed, input cell_type want);
      int gap;
      req_valid       <= 1'b1;
      req_left_edge   <= b.left_edge;
      req_right_edge  <= b.right_edge;
      req_top_edge    <= b.top_edge;
      req_bottom_edge <= b.bottom_edge;
      beat_fixed      <= fixed;
      beat_want       <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!tx_quiet) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scene_w_ff   <= RST_SCENE_SIZE;
         scene_h_ff   <= RST_SCENE_SIZE;
         max_level_ff <= RST_MAX_LEVEL;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCENE_WIDTH:  scene_w_ff   <= csr_data[SIZE_W-1:0];
            CSR_SCENE_HEIGHT: scene_h_ff   <= csr_data[SIZE_W-1:0];
            CSR_MAX_LEVEL:    max_level_ff <= csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_on   = !rx_quiet && ($urandom_range(0, 2) == 0);
         stall_left = $urandom_range(1, 20);
      end
      stall_left--;
      rsp_stall <= stall_on;
   end

   always @(posedge clock) begin
      cell_type got;
      cell_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_cell_x, rsp_cell_y, rsp_level, rsp_cell_index};
         if (expected_cells.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected beat: x=%0d y=%0d level=%0d index=%0d",
                        got.cell_x, got.cell_y, got.level, got.cell_index);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
                got.level !== want.level || got.cell_index !== want.cell_index) begin
               if (mismatches < 10)
                  $display("mismatch: expected x=%0d y=%0d level=%0d index=%0d,",
                           want.cell_x, want.cell_y, want.level, want.cell_index,
                           " got x=%0d y=%0d level=%0d index=%0d",
                           got.cell_x, got.cell_y, got.level, got.cell_index);
               mismatches++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         if (beat_fixed)
            expected_cells.insert(expected_cells.size(), beat_want);
         else
            expected_cells.insert(expected_cells.size(),
                                  cell_of_box({req_left_edge, req_right_edge,
                                               req_top_edge, req_bottom_edge}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[loose_quadtree_cell_index] ERROR");
      $finish;
   end

   initial begin
      probe_type probes [N_PROBES];
      int        k;
      int        s;
      probes = '{
         make_probe(0, 0, 0, 0,                      1, 0, 0, 8, 21845),
         make_probe(0, 1024, 0, 1024,                1, 0, 0, 0, 0),
         make_probe(-32768, 32767, -32768, 32767,    1, 0, 0, 0, 0),
         make_probe(32767, -32768, 32767, -32768,    1, 0, 0, 8, 21845),
         make_probe(32767, 32767, 32767, 32767,      1, 255, 255, 8, 87380),
         make_probe(-32768, -32768, -32768, -32768,  1, 0, 0, 8, 21845),
         make_probe(32767, 32767, -32768, 32767,     1, 0, 0, 0, 0),
         make_probe(0, 256, 0, 256,                  1, 0, 0, 1, 1),
         make_probe(768, 1024, 768, 1024,            1, 1, 1, 1, 4),
         make_probe(512, 512, 512, 512,              1, 128, 128, 8, 54741),
         make_probe(0, 1, 1023, 1024,                1, 0, 255, 8, 87125),
         make_probe(-1, 0, -1, 0,                    1, 0, 0, 8, 21845),
         make_probe(100, 104, 0, 0,                  0, 0, 0, 0, 0),
         make_probe(-300, -100, 50, 60,              0, 0, 0, 0, 0),
         make_probe(1000, 1100, 2000, 2010,          0, 0, 0, 0, 0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_PROBES; k++)
         send_box(probes[k].box, probes[k].fixed, probes[k].want);
      for (k = 0; k < 200; k++)
         send_box(random_box(), 1'b0, '0);

      for (s = 0; s < N_SETTINGS; s++) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (expected_cells.size() != 0) @(posedge clock);
         repeat (PIPE_DEPTH) @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= CSR_SCENE_WIDTH;
         csr_data  <= CSR_W'(scene_w_list[s]);
         @(posedge clock);
         csr_index <= CSR_SCENE_HEIGHT;
         csr_data  <= CSR_W'(scene_h_list[s]);
         @(posedge clock);
         csr_index <= CSR_MAX_LEVEL;
         csr_data  <= (CSR_W'($urandom) << LEVEL_W) | CSR_W'(max_lvl_list[s]);
         @(posedge clock);
         csr_index <= CSR_SPARE;
         csr_data  <= CSR_W'($urandom);
         @(posedge clock);
         csr_write <= 1'b0;
         tx_quiet = quiet_list[s];
         rx_quiet = quiet_list[s];
         @(posedge clock);
         for (k = 0; k < BOXES_PER_SETTING; k++)
            send_box(random_box(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatches == 0 && expected_cells.size() == 0)
         $display("[loose_quadtree_cell_index] OK");
      else
         $display("[loose_quadtree_cell_index] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
sv/lqci_pkg.sv
sv/lqci_axis_level.sv
sv/lqci_div_step.sv
sv/lqci_index.sv
sv/loose_quadtree_cell_index.sv
tb/tb_loose_quadtree_cell_index.sv
